FILE: hdl/ep2_self_energy_newton_assert.svh
// Assertion macros for the self-energy Newton block and its checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef EP2_SELF_ENERGY_NEWTON_ASSERT_SVH
`define EP2_SELF_ENERGY_NEWTON_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define EP2SEN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define EP2SEN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/ep2sen_pkg.sv
// Shared types, constants and saturating helpers for the self-energy Newton block.
// No dependencies.
package ep2sen_pkg;

  localparam logic [63:0] SIGN_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_TERM   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_CONV_THR = 1'b0;
  localparam logic [62:0] CONV_THR_RESET = 63'd1099512;

  // One orbital's state, kept in one RAM row.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] den;
    logic [63:0] old;
    logic [63:0] sigma;
    logic [63:0] deriv;
    logic        fault;
  } row_t;

  typedef struct packed {
    logic        trip;
    logic [63:0] res;
  } sat_t;

  typedef struct packed {
    logic start;
    logic div;   // 1: (a << F) / b, 0: (a * b) >> F
  } mdu_req_t;

  typedef struct packed {
    logic        done;
    logic        trip;
    logic [63:0] res;
  } mdu_rsp_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic sat_t sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                      input logic sub);
    sat_t        s;
    logic [63:0] r;
    logic        ovf;
    r   = sub ? (a - b) : (a + b);
    ovf = sub ? ((a[63] != b[63]) && (r[63] != a[63]))
              : ((a[63] == b[63]) && (r[63] != a[63]));
    s.trip = ovf;
    s.res  = ovf ? (a[63] ? SIGN_MIN : POS_MAX) : r;
    return s;
  endfunction

endpackage

FILE: hdl/ep2sen_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ep2sen_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/ep2sen_mdu.sv
// Shared iterative fixed-point unit: shift-add multiply and restoring divide,
// one bit per cycle, with signed saturation. Uses ep2sen_pkg.
module ep2sen_mdu #(
  parameter int unsigned FRACTION_BITS = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ep2sen_pkg::mdu_req_t  req_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  output ep2sen_pkg::mdu_rsp_t  rsp_o
);
  import ep2sen_pkg::*;

  localparam int unsigned DIV_STEPS = 64 + FRACTION_BITS;
  localparam int unsigned CW = $clog2(DIV_STEPS + 1);

  logic          busy_q, fin_q, done_q, div_q, neg_q, trip_q;
  logic [CW-1:0] cnt_q;
  logic [127:0]  acc_q, nreg_q;
  logic [63:0]   rem_q, mreg_q, res_q;

  logic [64:0]   msum, rshift;
  logic          ge;
  logic [127:0]  m;
  logic [63:0]   limit;
  logic          over;

  assign msum   = {1'b0, acc_q[127:64]} + (nreg_q[0] ? {1'b0, mreg_q} : 65'd0);
  assign rshift = {rem_q, nreg_q[127]};
  assign ge     = rshift >= {1'b0, mreg_q};

  assign m     = div_q ? acc_q : (acc_q >> FRACTION_BITS);
  assign limit = neg_q ? SIGN_MIN : POS_MAX;
  assign over  = (|m[127:64]) || (m[63:0] > limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin_q;
      fin_q  <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      div_q  <= req_i.div;
      neg_q  <= a_i[63] ^ b_i[63];
      mreg_q <= req_i.div ? mag(b_i) : mag(a_i);
      nreg_q <= req_i.div ? {mag(a_i), 64'd0} : {64'd0, mag(b_i)};
      acc_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= req_i.div ? CW'(DIV_STEPS - 1) : CW'(63);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (div_q) begin
        rem_q  <= ge ? 64'(rshift - {1'b0, mreg_q}) : rshift[63:0];
        acc_q  <= {acc_q[126:0], ge};
        nreg_q <= {nreg_q[126:0], 1'b0};
      end else begin
        acc_q  <= {msum, acc_q[63:1]};
        nreg_q <= {1'b0, nreg_q[127:1]};
      end
    end
    if (fin_q) begin
      trip_q <= over;
      res_q  <= over ? limit : (neg_q ? (64'd0 - m[63:0]) : m[63:0]);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.trip = trip_q;
  assign rsp_o.res  = res_q;

endmodule

FILE: hdl/ep2_self_energy_newton.sv
// Second-order self-energy accumulator with Newton update: sequencer, orbital RAM,
// config register. Uses ep2sen_pkg, ep2sen_ram, ep2sen_mdu.
//
// Input channel (in_valid_i/in_ready_o) takes one request per transfer:
//   load   - seeds an orbital row as it is accepted; no result.
//   term   - adds (2x-y)x/d and (2x-y)x/d^2 to the sums; no result. Runs one
//            multiply and two divides on the one bit-serial mul/div unit;
//            if d is zero it only marks the row faulty.
//   finish - one result on out_valid_o/out_ready_i, from two divides;
//            both are skipped if one plus the derivative sum is zero.
// Request code 3 and orbitals >= NUM_ORBITALS are dropped.
// in_ready_o is high only while the sequencer is idle; one request at a time.
// Results sit in an output register; a new finish waits there only if the
// previous result has not been taken yet. Other requests proceed meanwhile.
// Reset clears control and sets conv_threshold to its default; orbital rows
// are undefined until loaded. APB register 0 (64-bit data) is conv_threshold;
// the user must write it only while the block is idle; the block does not enforce this.
module ep2_self_energy_newton #(
  parameter int unsigned NUM_ORBITALS  = 64,
  parameter int unsigned FRACTION_BITS = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic [5:0]                        orbital_i,
  input  logic signed [63:0]                direct_integral_i,
  input  logic signed [63:0]                exchange_integral_i,
  input  logic signed [63:0]                eps_sub_first_i,
  input  logic signed [63:0]                eps_sub_second_i,
  input  logic signed [63:0]                eps_added_i,
  input  logic signed [63:0]                base_energy_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [5:0]                        orbital_out_o,
  output logic signed [63:0]                new_energy_o,
  output logic signed [63:0]                pole_strength_o,
  output logic [62:0]                       energy_change_o,
  output logic                              converged_o,
  output logic                              fault_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ep2sen_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);
  import ep2sen_pkg::*;

  localparam int unsigned AW = (NUM_ORBITALS > 1) ? $clog2(NUM_ORBITALS) : 1;
  localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS;

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001, S_RD   = 20'h00002, S_TD1  = 20'h00004, S_TD2  = 20'h00008,
    S_TD3  = 20'h00010, S_TP1  = 20'h00020, S_TP2  = 20'h00040, S_TMUL = 20'h00080,
    S_TDV1 = 20'h00100, S_TDV2 = 20'h00200, S_TSG  = 20'h00400, S_TDR  = 20'h00800,
    S_FNE  = 20'h01000, S_FD1  = 20'h02000, S_FCK  = 20'h04000, S_FPL  = 20'h08000,
    S_FDF  = 20'h10000, S_FQD  = 20'h20000, S_FNDN = 20'h40000, S_FCHG = 20'h80000
  } state_e;

  state_e      state_q, state_d;
  logic        trip_q, trip_d;
  logic        out_valid_q, out_valid_d;
  logic [62:0] thr_q;
  logic        is_term_q;

  row_t        row_q, row_d, rdata, wdata;
  logic [63:0] tmp_q, tmp_d, dv_q, dv_d, t1_q, t1_d, fresh_q, fresh_d, pole_q, pole_d;
  logic [63:0] x_q, y_q, e1_q, e2_q, e3_q;
  logic [5:0]  orb_q;

  logic        accept, in_range, we, add_en, sub;
  logic [63:0] op_a, op_b, mop_a, mop_b;
  sat_t        sat;
  mdu_req_t    mreq;
  mdu_rsp_t    mrsp;

  logic [64:0] diff, absd;
  logic        chg_over, out_load;
  logic [62:0] change;

  logic [5:0]  oorb_q;
  logic [63:0] onew_q, opole_q;
  logic [62:0] ochg_q;
  logic        oconv_q, ofault_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = 32'(orbital_i) < NUM_ORBITALS;

  assign sat = sat_addsub(op_a, op_b, sub);

  assign diff     = {fresh_q[63], fresh_q} - {row_q.old[63], row_q.old};
  assign absd     = diff[64] ? (65'd0 - diff) : diff;
  assign chg_over = absd[64] | absd[63];
  assign change   = chg_over ? POS_MAX[62:0] : absd[62:0];

  always_comb begin
    state_d     = state_q;
    trip_d      = trip_q;
    out_valid_d = out_valid_q && !out_ready_i;
    row_d       = row_q;
    tmp_d       = tmp_q;
    dv_d        = dv_q;
    t1_d        = t1_q;
    fresh_d     = fresh_q;
    pole_d      = pole_q;
    op_a        = tmp_q;
    op_b        = 64'd0;
    sub         = 1'b0;
    add_en      = 1'b0;
    mreq        = '0;
    mop_a       = tmp_q;
    mop_b       = dv_q;
    we          = 1'b0;
    wdata       = row_q;
    out_load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        trip_d = 1'b0;
        if (accept && in_range) begin
          case (req_type_i)
            REQ_LOAD: begin
              we          = 1'b1;
              wdata.base  = base_energy_i;
              wdata.den   = base_energy_i;
              wdata.old   = base_energy_i;
              wdata.sigma = '0;
              wdata.deriv = '0;
              wdata.fault = 1'b0;
            end
            REQ_TERM, REQ_FINISH: state_d = S_RD;
            default: ;
          endcase
        end
      end
      S_RD: begin
        row_d   = rdata;
        state_d = is_term_q ? S_TD1 : S_FNE;
      end
      S_TD1: begin
        add_en = 1'b1; op_a = row_q.den; op_b = e1_q; sub = 1'b1;
        tmp_d = sat.res; state_d = S_TD2;
      end
      S_TD2: begin
        add_en = 1'b1; op_b = e2_q; sub = 1'b1;
        tmp_d = sat.res; state_d = S_TD3;
      end
      S_TD3: begin
        add_en = 1'b1; op_b = e3_q;
        dv_d = sat.res; state_d = S_TP1;
      end
      S_TP1: begin
        if (dv_q == '0) begin
          we          = 1'b1;
          wdata.fault = 1'b1;
          state_d     = S_IDLE;
        end else begin
          add_en = 1'b1; op_a = x_q; op_b = x_q;
          tmp_d = sat.res; state_d = S_TP2;
        end
      end
      S_TP2: begin
        add_en = 1'b1; op_b = y_q; sub = 1'b1;
        mreq.start = 1'b1; mop_a = sat.res; mop_b = x_q;
        state_d = S_TMUL;
      end
      S_TMUL: begin
        if (mrsp.done) begin
          mreq.start = 1'b1; mreq.div = 1'b1; mop_a = mrsp.res;
          state_d = S_TDV1;
        end
      end
      S_TDV1: begin
        if (mrsp.done) begin
          t1_d = mrsp.res;
          mreq.start = 1'b1; mreq.div = 1'b1; mop_a = mrsp.res;
          state_d = S_TDV2;
        end
      end
      S_TDV2: begin
        if (mrsp.done) begin
          tmp_d = mrsp.res; state_d = S_TSG;
        end
      end
      S_TSG: begin
        add_en = 1'b1; op_a = row_q.sigma; op_b = t1_q;
        row_d.sigma = sat.res; state_d = S_TDR;
      end
      S_TDR: begin
        add_en = 1'b1; op_a = row_q.deriv; op_b = tmp_q;
        we          = 1'b1;
        wdata.deriv = sat.res;
        wdata.fault = row_q.fault | trip_q | sat.trip;
        state_d     = S_IDLE;
      end
      S_FNE: begin
        add_en = 1'b1; op_a = row_q.base; op_b = row_q.sigma;
        fresh_d = sat.res; state_d = S_FD1;
      end
      S_FD1: begin
        add_en = 1'b1; op_a = ONE; op_b = row_q.deriv;
        dv_d = sat.res; state_d = S_FCK;
      end
      S_FCK: begin
        if (dv_q == '0) begin
          trip_d  = 1'b1;
          pole_d  = '0;
          state_d = S_FCHG;
        end else begin
          mreq.start = 1'b1; mreq.div = 1'b1; mop_a = ONE;
          state_d = S_FPL;
        end
      end
      S_FPL: begin
        if (mrsp.done) begin
          pole_d = mrsp.res; state_d = S_FDF;
        end
      end
      S_FDF: begin
        add_en = 1'b1; op_a = row_q.old; op_b = fresh_q; sub = 1'b1;
        mreq.start = 1'b1; mreq.div = 1'b1; mop_a = sat.res;
        state_d = S_FQD;
      end
      S_FQD: begin
        if (mrsp.done) begin
          tmp_d = mrsp.res; state_d = S_FNDN;
        end
      end
      S_FNDN: begin
        add_en = 1'b1; op_a = row_q.old; op_b = tmp_q; sub = 1'b1;
        row_d.den = sat.res; state_d = S_FCHG;
      end
      S_FCHG: begin
        // hold here while the previous result is still waiting
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          we          = 1'b1;
          wdata.old   = fresh_q;
          wdata.sigma = '0;
          wdata.deriv = '0;
          wdata.fault = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (add_en && sat.trip) begin
      trip_d = 1'b1;
    end
    if (mrsp.done && mrsp.trip) begin
      trip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      trip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= CONV_THR_RESET;
    end else begin
      state_q     <= state_d;
      trip_q      <= trip_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && (paddr == ADDR_CONV_THR)) begin
        thr_q <= pwdata[62:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    tmp_q   <= tmp_d;
    dv_q    <= dv_d;
    t1_q    <= t1_d;
    fresh_q <= fresh_d;
    pole_q  <= pole_d;
    if (accept) begin
      is_term_q <= (req_type_i == REQ_TERM);
      orb_q     <= orbital_i;
      x_q       <= direct_integral_i;
      y_q       <= exchange_integral_i;
      e1_q      <= eps_sub_first_i;
      e2_q      <= eps_sub_second_i;
      e3_q      <= eps_added_i;
    end
    if (out_load) begin
      oorb_q   <= orb_q;
      onew_q   <= fresh_q;
      opole_q  <= pole_q;
      ochg_q   <= change;
      oconv_q  <= change < thr_q;
      ofault_q <= trip_q | chg_over | row_q.fault;
    end
  end

  ep2sen_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NUM_ORBITALS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (accept ? AW'(orbital_i) : AW'(orb_q)),
    .wdata_i (wdata),
    .raddr_i (AW'(orbital_i)),
    .rdata_o (rdata)
  );

  ep2sen_mdu #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (mop_a),
    .b_i    (mop_b),
    .rsp_o  (mrsp)
  );

  assign out_valid_o     = out_valid_q;
  assign orbital_out_o   = oorb_q;
  assign new_energy_o    = onew_q;
  assign pole_strength_o = opole_q;
  assign energy_change_o = ochg_q;
  assign converged_o     = oconv_q;
  assign fault_o         = ofault_q;

  assign prdata = (paddr == ADDR_CONV_THR) ? {1'b0, thr_q} : 64'd0;
  assign pready = 1'b1;

endmodule

FILE: hdl/ep2sen_checker.sv
// Port-level checks for ep2_self_energy_newton, bound to the top level.
// Uses ep2sen_pkg and ep2_self_energy_newton_assert.svh.
`include "ep2_self_energy_newton_assert.svh"

module ep2sen_checker #(
  parameter int unsigned NUM_ORBITALS = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  req_type_i,
  input logic [5:0]  orbital_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] new_energy_o
);
  import ep2sen_pkg::*;

  logic acc_load, acc_none;

  assign acc_load = in_valid_i && in_ready_o && (req_type_i == REQ_LOAD);
  assign acc_none = in_valid_i && in_ready_o &&
                    ((req_type_i != REQ_LOAD && req_type_i != REQ_TERM &&
                      req_type_i != REQ_FINISH) || (32'(orbital_i) >= NUM_ORBITALS));

  `EP2SEN_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_energy_o), "result dropped or changed while stalled")
  `EP2SEN_ASSERT(a_load_fast, acc_load |=> in_ready_o, "load transfer must finish in one cycle")
  `EP2SEN_ASSERT(a_drop_fast, acc_none |=> in_ready_o, "ignored request must not hold the block")
  `EP2SEN_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind ep2_self_energy_newton ep2sen_checker #(.NUM_ORBITALS(NUM_ORBITALS)) u_checker (.*);

FILE: test/tb.sv
// Testbench for ep2_self_energy_newton: directed and random load/term/finish traffic,
// checked against an in-bench fixed-point predictor of the orbital sums and Newton step.
// Depends on ep2sen_pkg and the RTL of the block.
module tb;
  import ep2sen_pkg::*;

  localparam int          FRAC      = 40;
  localparam int          NORB      = 64;
  localparam int          DRAIN     = 400;    // longer than a term or finish
  localparam int          WDOG_MAX  = 20000;
  localparam int          N_ITEMS   = 1050;
  localparam logic [63:0] ONE       = 64'd1 << FRAC;
  localparam logic [63:0] MIN_S     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S     = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  orb;
    logic [63:0] x, y, e1, e2, e3, base;
  } req_t;

  typedef struct packed {
    logic [5:0]  orb;
    logic [63:0] energy, pole;
    logic [62:0] change;
    logic        conv, fault;
  } orb_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid = 1'b0, out_ready = 1'b0;
  logic [1:0] req_type = REQ_LOAD;
  logic [5:0] orbital = '0;
  logic signed [63:0] dir_int = '0, exc_int = '0, eps1 = '0, eps2 = '0, eps3 = '0, base_e = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = ADDR_CONV_THR;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready, in_ready_o, out_valid_o, converged_o, fault_o;
  logic [5:0] orbital_out_o;
  logic signed [63:0] new_energy_o, pole_strength_o;
  logic [62:0] energy_change_o;

  ep2_self_energy_newton dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o,
    .req_type_i(req_type), .orbital_i(orbital),
    .direct_integral_i(dir_int), .exchange_integral_i(exc_int),
    .eps_sub_first_i(eps1), .eps_sub_second_i(eps2), .eps_added_i(eps3),
    .base_energy_i(base_e),
    .out_valid_o, .out_ready_i(out_ready),
    .orbital_out_o, .new_energy_o, .pole_strength_o, .energy_change_o,
    .converged_o, .fault_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // Predictor state, one row per orbital
  logic [63:0] orb_base[NORB], orb_den[NORB], orb_old[NORB], orb_sigma[NORB], orb_deriv[NORB];
  logic        orb_fault[NORB], loaded[NORB];
  logic [62:0] thr = CONV_THR_RESET;
  logic        sat_hit;
  orb_result_t result_q[$];
  int          n_sent = 0, n_bad = 0, stall_left = 0;
  bit          calm = 0;

  function automatic logic [63:0] add_s(logic [63:0] a, logic [63:0] b);
    logic [63:0] r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sat_hit = 1'b1;
      return a[63] ? MIN_S : MAX_S;
    end
    return r;
  endfunction

  function automatic logic [63:0] sub_s(logic [63:0] a, logic [63:0] b);
    logic [63:0] r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      sat_hit = 1'b1;
      return a[63] ? MIN_S : MAX_S;
    end
    return r;
  endfunction

  function automatic logic [127:0] abs128(logic [63:0] v);
    return {64'd0, (v[63] ? 64'd0 - v : v)};
  endfunction

  function automatic logic [63:0] clamp(logic [127:0] m, logic neg);
    if (m > {64'd0, (neg ? MIN_S : MAX_S)}) begin
      sat_hit = 1'b1;
      return neg ? MIN_S : MAX_S;
    end
    return neg ? 64'd0 - m[63:0] : m[63:0];
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return clamp((abs128(a) * abs128(b)) >> FRAC, a[63] ^ b[63]);
  endfunction

  function automatic logic [63:0] qdiv(logic [63:0] n, logic [63:0] d);
    return clamp((abs128(n) << FRAC) / abs128(d), n[63] ^ d[63]);
  endfunction

  // Advance the orbital state for one accepted request; queue a result for finish.
  task automatic predict(req_t r);
    logic [63:0] d, numer, t1, fresh, old, den1, pole, chg;
    orb_result_t res;
    int o = r.orb;
    sat_hit = 1'b0;
    case (r.kind)
      REQ_LOAD: begin
        orb_base[o] = r.base; orb_den[o] = r.base; orb_old[o] = r.base;
        orb_sigma[o] = '0; orb_deriv[o] = '0; orb_fault[o] = 1'b0; loaded[o] = 1'b1;
      end
      REQ_TERM: begin
        d = add_s(sub_s(sub_s(orb_den[o], r.e1), r.e2), r.e3);
        if (d == 0) orb_fault[o] = 1'b1;
        else begin
          numer = qmul(sub_s(add_s(r.x, r.x), r.y), r.x);
          t1 = qdiv(numer, d);
          orb_sigma[o] = add_s(orb_sigma[o], t1);
          orb_deriv[o] = add_s(orb_deriv[o], qdiv(t1, d));
          if (sat_hit) orb_fault[o] = 1'b1;
        end
      end
      REQ_FINISH: begin
        old = orb_old[o];
        fresh = add_s(orb_base[o], orb_sigma[o]);
        den1 = add_s(ONE, orb_deriv[o]);
        pole = '0;
        if (den1 == 0) sat_hit = 1'b1;
        else begin
          pole = qdiv(ONE, den1);
          orb_den[o] = sub_s(old, qdiv(sub_s(old, fresh), den1));
        end
        chg = ((fresh ^ MIN_S) >= (old ^ MIN_S)) ? fresh - old : old - fresh;
        if (chg > MAX_S) begin
          chg = MAX_S;
          sat_hit = 1'b1;
        end
        res.orb = r.orb; res.energy = fresh; res.pole = pole; res.change = chg[62:0];
        res.conv = chg[62:0] < thr; res.fault = sat_hit | orb_fault[o];
        result_q = {result_q, res};
        orb_old[o] = fresh; orb_sigma[o] = '0; orb_deriv[o] = '0; orb_fault[o] = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic send_req(req_t r);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= r.kind; orbital <= r.orb; dir_int <= r.x; exc_int <= r.y;
    eps1 <= r.e1; eps2 <= r.e2; eps3 <= r.e3; base_e <= r.base;
    do @(posedge clk_i); while (!in_ready_o);
    predict(r);
    n_sent++;
  endtask

  function automatic req_t mk(logic [1:0] k, logic [5:0] o, logic [63:0] x = 0,
                              logic [63:0] y = 0, logic [63:0] e1 = 0, logic [63:0] e2 = 0,
                              logic [63:0] e3 = 0, logic [63:0] b = 0);
    req_t r;
    r.kind = k; r.orb = o; r.x = x; r.y = y; r.e1 = e1; r.e2 = e2; r.e3 = e3; r.base = b;
    return r;
  endfunction

  // Mostly a random pattern shifted right arithmetically by shift bits; now and then any 64-bit pattern.
  function automatic logic [63:0] rnd_q(int shift);
    logic signed [63:0] v = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return v;
    return v >>> shift;
  endfunction

  // Term whose denominator comes out as the smallest positive step.
  task automatic unit_den_term(logic [5:0] o, logic [63:0] x, logic [63:0] y);
    send_req(mk(REQ_TERM, o, x, y, orb_den[o], 0, 64'd1));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [62:0] val);
    wait_results();
    repeat (DRAIN) @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_CONV_THR; pwdata <= {1'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thr = val;
  endtask

  task automatic test_directed();
    send_req(mk(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(REQ_LOAD, 1, 0, 0, 0, 0, 0, MIN_S));
    send_req(mk(REQ_LOAD, 2, 0, 0, 0, 0, 0, MAX_S));
    send_req(mk(REQ_LOAD, 3, 0, 0, 0, 0, 0, ONE));
    send_req(mk(REQ_TERM, 0, rnd_q(26), rnd_q(26), rnd_q(20), rnd_q(20), rnd_q(20)));
    send_req(mk(REQ_TERM, 0, MAX_S, MIN_S, MIN_S, MAX_S, MIN_S));
    send_req(mk(REQ_FINISH, 0));
    // zero denominator: skipped and flagged
    send_req(mk(REQ_TERM, 1, ONE, ONE, orb_den[1]));
    send_req(mk(REQ_FINISH, 1));
    // derivative sum of exactly -1: no pole strength, denominator kept
    send_req(mk(REQ_TERM, 3, ONE, 3 * ONE));
    send_req(mk(REQ_FINISH, 3));
    // change beyond the 63-bit range
    send_req(mk(REQ_LOAD, 4));
    unit_den_term(4, ONE, 0);
    send_req(mk(REQ_FINISH, 4));
    unit_den_term(4, ONE, 4 * ONE);
    send_req(mk(REQ_FINISH, 4));
    send_req(mk(REQ_TERM, 2, MIN_S, MAX_S, MAX_S, MIN_S, MAX_S));
    send_req(mk(REQ_FINISH, 2));
    send_req(mk(REQ_UNUSED, 5, {$urandom, $urandom}, {$urandom, $urandom}, '1, '1, '1, '1));
    send_req(mk(REQ_LOAD, 63, 0, 0, 0, 0, 0, rnd_q(20)));
    send_req(mk(REQ_FINISH, 63));
    wait_results();
  endtask

  task automatic test_thresholds();
    write_threshold('1);
    send_req(mk(REQ_TERM, 0, rnd_q(30), rnd_q(30), rnd_q(20), rnd_q(20), rnd_q(20)));
    send_req(mk(REQ_FINISH, 0));
    send_req(mk(REQ_FINISH, 4));
    write_threshold('0);
    send_req(mk(REQ_FINISH, 0));
    send_req(mk(REQ_FINISH, 63));
  endtask

  // Well-formed orbital iterations with random content, plus some noise.
  task automatic random_iterations(int upto);
    logic [5:0] o;
    int nterm;
    while (n_sent < upto) begin
      o = $urandom_range(0, NORB - 1);
      if ($urandom_range(0, 15) == 0) begin
        send_req(mk(REQ_UNUSED, o, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}));
        continue;
      end
      if (!loaded[o] || $urandom_range(0, 7) == 0)
        send_req(mk(REQ_LOAD, o, rnd_q(26), rnd_q(26), rnd_q(20), rnd_q(20), rnd_q(20),
                    rnd_q(20)));
      nterm = $urandom_range(0, 4);
      repeat (nterm) begin
        if ($urandom_range(0, 19) == 0) unit_den_term(o, rnd_q(30), rnd_q(30));
        else send_req(mk(REQ_TERM, o, rnd_q(26), rnd_q(26), rnd_q(20), rnd_q(20), rnd_q(20),
                         rnd_q(20)));
      end
      if ($urandom_range(0, 9) != 0) send_req(mk(REQ_FINISH, o, rnd_q(20), rnd_q(20)));
    end
  endtask

  task automatic test_random();
    random_iterations(300);
    write_threshold(63'd1 << $urandom_range(20, 44));
    random_iterations(550);
    write_threshold({$urandom, $urandom});
    random_iterations(800);
    write_threshold(CONV_THR_RESET);
    calm = 1;
    random_iterations(N_ITEMS);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && rst_ni && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    orb_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (result_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result for orbital %0d", orbital_out_o);
      end else begin
        want = result_q.pop_front();
        if (orbital_out_o !== want.orb || new_energy_o !== want.energy ||
            pole_strength_o !== want.pole || energy_change_o !== want.change ||
            converged_o !== want.conv || fault_o !== want.fault) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp orb %0d E %h P %h dE %h c %b f %b / got %0d %h %h %h %b %b",
                     want.orb, want.energy, want.pole, want.change, want.conv, want.fault,
                     orbital_out_o, new_energy_o, pole_strength_o, energy_change_o,
                     converged_o, fault_o);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    for (int i = 0; i < NORB; i++) loaded[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_thresholds();
    test_random();
    wait_results();
    repeat (DRAIN) @(posedge clk_i);
    if (n_bad == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
